FILE: hw/rtl/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and codes of the indexed array list: request and result words,
// operation and status codes, and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package ial_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         position;
    logic signed [31:0] data_word;
  } ial_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_word;
    logic [5:0]         found_position;
    logic [6:0]         entry_count;
  } ial_out_t;

  // One command for the whole row of cells in a given cycle.
  typedef struct packed {
    logic ins;   // shift up from the position and write the key there
    logic rem;   // shift down from the position
    logic get;   // mark the cell at the position
    logic srch;  // mark the cells holding the key
  } ial_ctl_t;

endpackage

FILE: hw/rtl/ial_cell.sv
// ----------------------------------------------------------------------------
// ial_cell
// One storage cell of the list. It holds a single entry, takes its left or
// right neighbor's word on a shift, and registers a hit flag for lookups.
// ----------------------------------------------------------------------------
module ial_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CMP_W      = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  ial_pkg::ial_ctl_t     ctl,
  input  logic [CMP_W-1:0]      pos,
  input  logic [CMP_W-1:0]      count,
  input  logic [WORD_WIDTH-1:0] key,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  leaf_hit,
  output logic [WORD_WIDTH-1:0] leaf_word
);
  import ial_pkg::*;

  localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);

  logic [WORD_WIDTH-1:0] entry_r;
  logic [WORD_WIDTH-1:0] entry_nxt;
  logic                  hit_r;
  logic                  hit_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (IDX_C > pos) begin
        entry_nxt = left_word;
      end else if (IDX_C == pos) begin
        entry_nxt = key;
      end
    end else if (ctl.rem) begin
      if (IDX_C >= pos) begin
        entry_nxt = right_word;
      end
    end
  end

  always_comb begin
    if (ctl.get) begin
      hit_nxt = (IDX_C == pos);
    end else begin
      hit_nxt = (entry_r == key) && (IDX_C < count);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.get || ctl.srch) begin
      hit_r <= hit_nxt;
    end
  end

  assign word      = entry_r;
  assign leaf_hit  = hit_r;
  assign leaf_word = entry_r;

endmodule

FILE: hw/rtl/ial_tree.sv
// ----------------------------------------------------------------------------
// ial_tree
// Registered binary tree over the cells' hit flags. Each node keeps the
// lowest-indexed hit below it together with that cell's word.
// ----------------------------------------------------------------------------
module ial_tree #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       leaf_hit  [CAPACITY],
  input  logic [WORD_WIDTH-1:0]      leaf_word [CAPACITY],
  output logic                       root_hit,
  output logic [$clog2(CAPACITY)-1:0] root_idx,
  output logic [WORD_WIDTH-1:0]      root_word
);
  import ial_pkg::*;

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int NPAD   = 1 << LEVELS;

  // Heap layout: node k has children 2k and 2k+1, leaves sit at NPAD + j.
  logic                  node_hit  [2*NPAD-1:1];
  logic [LEVELS-1:0]     node_idx  [2*NPAD-1:1];
  logic [WORD_WIDTH-1:0] node_word [2*NPAD-1:1];

  for (genvar j = 0; j < NPAD; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_real
      assign node_hit[NPAD+j]  = leaf_hit[j];
      assign node_word[NPAD+j] = leaf_word[j];
    end else begin : g_pad
      assign node_hit[NPAD+j]  = 1'b0;
      assign node_word[NPAD+j] = '0;
    end
    assign node_idx[NPAD+j] = LEVELS'(j);
  end

  for (genvar k = 1; k < NPAD; k++) begin : g_node
    always_ff @(posedge clk) begin
      node_hit[k] <= node_hit[2*k] | node_hit[2*k+1];
      if (node_hit[2*k]) begin
        node_idx[k]  <= node_idx[2*k];
        node_word[k] <= node_word[2*k];
      end else begin
        node_idx[k]  <= node_idx[2*k+1];
        node_word[k] <= node_word[2*k+1];
      end
    end
  end

  assign root_hit  = node_hit[1];
  assign root_idx  = node_idx[1];
  assign root_word = node_word[1];

endmodule

FILE: hw/rtl/indexed_array_list.sv
// ----------------------------------------------------------------------------
// indexed_array_list
// Ordered list of signed words kept in a row of cells, with insert, remove,
// get and search requests and one result word per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Insert, remove and any rejected request
// go straight to the result register: the cells from the given position up
// shift by one place in the cycle the request is accepted. A valid get
// and any search wait in a scan state until the registered tree that picks
// the lowest matching cell has settled, and then register their result.
// A new request is accepted as soon as the previous result has moved into the
// output register, even while that result still waits to be taken. Entries
// are not cleared by reset; only positions below the current count are read.
module indexed_array_list #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ial_pkg::ial_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ial_pkg::ial_out_t out_data
);
  import ial_pkg::*;

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CW > 7) ? CW : 7;
  localparam int SCW    = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SCW-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic             srch_r, srch_nxt;
  ial_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  ial_out_t         out_data_r, out_data_nxt;

  logic             in_fire;
  logic             out_load;
  ial_ctl_t         ctl;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic             ins_bad;
  logic             acc_bad;
  logic             full;
  logic [WORD_WIDTH-1:0] key;

  logic [WORD_WIDTH-1:0]   cell_word [CAPACITY];
  logic                    leaf_hit  [CAPACITY];
  logic [WORD_WIDTH-1:0]   leaf_word [CAPACITY];
  logic                    root_hit;
  logic [LEVELS-1:0]       root_idx;
  logic [WORD_WIDTH-1:0]   root_word;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  assign pos_ext   = CMP_W'(in_data.position);
  assign count_ext = CMP_W'(count_r);
  assign key       = WORD_WIDTH'(in_data.data_word);
  assign ins_bad   = pos_ext > count_ext;
  assign acc_bad   = pos_ext >= count_ext;
  assign full      = (count_r == CW'(CAPACITY));

  always_comb begin
    ctl.ins  = in_fire && (in_data.kind == KIND_INSERT) && !ins_bad && !full;
    ctl.rem  = in_fire && (in_data.kind == KIND_REMOVE) && !acc_bad;
    ctl.get  = in_fire && (in_data.kind == KIND_GET) && !acc_bad;
    ctl.srch = in_fire && (in_data.kind == KIND_SEARCH);
  end

  // Row of cells; the ends see their own word or the key on the open side.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = key;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    ial_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CMP_W      (CMP_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_ext),
      .count      (count_ext),
      .key        (key),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .leaf_hit   (leaf_hit[i]),
      .leaf_word  (leaf_word[i])
    );
  end

  ial_tree #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (leaf_hit),
    .leaf_word (leaf_word),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_word (root_word)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_cnt_nxt = scan_cnt_r;
    srch_nxt     = srch_r;
    res_nxt      = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt.status         = STATUS_OK;
          res_nxt.read_word      = '0;
          res_nxt.found_position = '0;
          srch_nxt               = ctl.srch;
          if (ctl.ins) begin
            count_nxt = count_r + 1'b1;
          end else if (ctl.rem) begin
            count_nxt = count_r - 1'b1;
          end
          if ((in_data.kind == KIND_INSERT) && ins_bad) begin
            res_nxt.status = STATUS_RANGE;
          end else if ((in_data.kind == KIND_INSERT) && full) begin
            res_nxt.status = STATUS_FULL;
          end else if ((in_data.kind != KIND_INSERT) &&
                       (in_data.kind != KIND_SEARCH) && acc_bad) begin
            res_nxt.status = STATUS_RANGE;
          end
          res_nxt.entry_count = 7'(count_nxt);
          if (ctl.get || ctl.srch) begin
            scan_cnt_nxt = SCW'(LEVELS);
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == '0) begin
          if (srch_r) begin
            if (root_hit) begin
              res_nxt.found_position = 6'(root_idx);
            end else begin
              res_nxt.status = STATUS_NOT_FOUND;
            end
          end else begin
            res_nxt.read_word = 32'($signed(root_word));
          end
          state_nxt = ST_HOLD;
        end else begin
          scan_cnt_nxt = scan_cnt_r - 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srch_r     <= srch_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count can never pass the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted insert that passed its checks grows the list by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the list by one");

  // The tree walk is not cut short before the root has settled.
  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (scan_cnt_r != '0)) |=> (state_r == ST_SCAN))
    else $error("scan left before the tree settled");

  // A result is only handed over from the hold state into a free register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks indexed_array_list against a list model kept inside a scoreboard.
// Directed requests cover the edges of the list, then random phases fill,
// mix and drain it while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ial_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 250;
  localparam int SETTLE       = 20;

  typedef enum int {
    PHASE_MIXED,
    PHASE_FILL,
    PHASE_DRAIN
  } phase_t;

  class list_scoreboard;
    logic signed [31:0] cells [LIST_DEPTH];
    int                 used;
    ial_out_t           expected_results [$];
    int                 errors;
    int                 kind_seen [4];
    int                 status_seen [4];
    int                 peak;

    // Applies one accepted request to the list and queues the result it
    // should produce.
    function void note_request(ial_in_t req);
      ial_out_t res;
      int       pos;
      int       i;
      bit       hit;
      res = '0;
      pos = req.position;
      hit = 1'b0;
      case (kind_t'(req.kind))
        KIND_INSERT: begin
          // The range check wins over the full check.
          if (pos > used) begin
            res.status = STATUS_RANGE;
          end else if (used >= LIST_DEPTH) begin
            res.status = STATUS_FULL;
          end else begin
            for (i = used; i > pos; i--) cells[i] = cells[i - 1];
            cells[pos] = req.data_word;
            used++;
          end
        end
        KIND_REMOVE: begin
          if (pos >= used) begin
            res.status = STATUS_RANGE;
          end else begin
            for (i = pos; i + 1 < used; i++) cells[i] = cells[i + 1];
            used--;
          end
        end
        KIND_GET: begin
          if (pos >= used) begin
            res.status = STATUS_RANGE;
          end else begin
            res.read_word = cells[pos];
          end
        end
        KIND_SEARCH: begin
          for (i = 0; i < used; i++) begin
            if (!hit && cells[i] == req.data_word) begin
              hit = 1'b1;
              res.found_position = 6'(i);
            end
          end
          if (!hit) res.status = STATUS_NOT_FOUND;
        end
      endcase
      res.entry_count = 7'(used);
      if (used > peak) peak = used;
      kind_seen[req.kind]++;
      status_seen[res.status]++;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ial_out_t got);
      ial_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("read_word", want.read_word, got.read_word);
      compare_field("found_position", want.found_position, got.found_position);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ial_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ial_out_t out_data;

  list_scoreboard sb;
  int             requests_sent = 0;
  bit             steady        = 1'b0;
  bit             held_off      = 1'b0;
  int             idle_cycles   = 0;

  indexed_array_list uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function logic signed [31:0] pool_word();
    case ($urandom_range(0, 7))
      0: return 32'sh0000_0000;
      1: return -32'sd1;
      2: return 32'sd1;
      3: return 32'sh7fff_ffff;
      4: return 32'sh8000_0000;
      5: return 32'sd5;
      6: return 32'sd42;
      default: return -32'sd42;
    endcase
  endfunction

  // Offers one request word, waits for it to be taken, then may idle a while.
  task automatic send_request(kind_t k, int pos, logic signed [31:0] w);
    ial_in_t req;
    int      g;
    req.kind      = k;
    req.position  = pos[6:0];
    req.data_word = w;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic pick_fields(phase_t mode, output kind_t k, output int pos,
                             output logic signed [31:0] w);
    int r;
    int ins_w;
    int rem_w;
    int get_w;
    case (mode)
      PHASE_FILL: begin
        ins_w = 75; rem_w = 5; get_w = 10;
      end
      PHASE_DRAIN: begin
        ins_w = 5; rem_w = 75; get_w = 10;
      end
      default: begin
        ins_w = 35; rem_w = 25; get_w = 20;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) k = KIND_INSERT;
    else if (r < ins_w + rem_w) k = KIND_REMOVE;
    else if (r < ins_w + rem_w + get_w) k = KIND_GET;
    else k = KIND_SEARCH;

    r = $urandom_range(0, 99);
    if (r < 85) begin
      if (k == KIND_INSERT) pos = $urandom_range(0, sb.used);
      else if (k == KIND_SEARCH || sb.used == 0) pos = $urandom_range(0, 127);
      else pos = $urandom_range(0, sb.used - 1);
    end else if (r < 95) begin
      pos = sb.used + $urandom_range(0, 1);
    end else begin
      pos = $urandom_range(0, 127);
    end

    // Searches mostly look for a value that is in the list.
    r = $urandom_range(0, 99);
    if (k == KIND_SEARCH && sb.used > 0 && r < 70) w = sb.cells[$urandom_range(0, sb.used - 1)];
    else if (r < 85) w = pool_word();
    else w = $urandom;
  endtask

  // Result side: random ready pattern, plus one long hold-off that lets the
  // block fill up and stall the input side.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && requests_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        stall    = HOLD_CYCLES;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    phase_t             mode;
    kind_t              k;
    int                 pos;
    logic signed [31:0] w;
    int                 p;
    int                 n;
    int                 i;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: everything is out of range or missing.
    send_request(KIND_GET, 0, 32'sd0);
    send_request(KIND_REMOVE, 0, 32'sd0);
    send_request(KIND_SEARCH, 0, 32'sd5);
    send_request(KIND_INSERT, 1, 32'sd7);
    // Build a short list with the extreme values and a duplicate at the end.
    send_request(KIND_INSERT, 0, 32'sh8000_0000);
    send_request(KIND_INSERT, 1, 32'sh7fff_ffff);
    send_request(KIND_INSERT, 0, -32'sd1);
    send_request(KIND_INSERT, 2, 32'sd0);
    send_request(KIND_INSERT, 4, 32'sh7fff_ffff);
    send_request(KIND_SEARCH, 127, 32'sh7fff_ffff);
    send_request(KIND_SEARCH, 0, -32'sd1);
    send_request(KIND_SEARCH, 0, 32'sd12345);
    send_request(KIND_GET, 0, 32'sd0);
    send_request(KIND_GET, 4, -32'sd1);
    send_request(KIND_GET, 5, 32'sd0);
    send_request(KIND_GET, 127, 32'sd0);
    send_request(KIND_REMOVE, 2, 32'sd0);
    send_request(KIND_REMOVE, 0, 32'sd0);
    send_request(KIND_REMOVE, sb.used - 1, 32'sd0);
    send_request(KIND_REMOVE, 127, 32'sd0);
    send_request(KIND_INSERT, 127, 32'sd3);
    send_request(KIND_INSERT, sb.used + 1, 32'sd3);

    n = 0;
    for (p = 0; n < RANDOM_ITEMS; p++) begin
      case (p % 4)
        1: mode = PHASE_FILL;
        3: mode = PHASE_DRAIN;
        default: mode = PHASE_MIXED;
      endcase
      steady = (p % 3 == 2);
      // Fill and drain phases keep going until the list is full or empty, or 300 requests.
      for (i = 0; i < 300 && (i < 80 || (mode == PHASE_FILL && sb.used < LIST_DEPTH) ||
                              (mode == PHASE_DRAIN && sb.used > 0)); i++) begin
        pick_fields(mode, k, pos, w);
        send_request(k, pos, w);
        n++;
      end
      if (mode == PHASE_FILL) begin
        // Inserts into a full list, in range and beyond it.
        send_request(KIND_INSERT, sb.used, $urandom);
        send_request(KIND_INSERT, 0, $urandom);
        send_request(KIND_INSERT, sb.used + 1, $urandom);
        n += 3;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests: %0d inserts, %0d removes, %0d gets, %0d searches.",
             requests_sent, sb.kind_seen[KIND_INSERT], sb.kind_seen[KIND_REMOVE],
             sb.kind_seen[KIND_GET], sb.kind_seen[KIND_SEARCH]);
    $display("Results ok %0d, out of range %0d, full %0d, not found %0d; peak length %0d.",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANGE],
             sb.status_seen[STATUS_FULL], sb.status_seen[STATUS_NOT_FOUND], sb.peak);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ial_pkg.sv
hw/rtl/ial_cell.sv
hw/rtl/ial_tree.sv
hw/rtl/indexed_array_list.sv
sim/testbench.sv
